>>> rtl/core/kh_pkg.sv
// Package for the key hash slice selector.
// Holds the queue entry type, queue status type and back-end state enum.
// No dependencies.
package kh_pkg;

  // Hash width and the number of restoring modulo steps
  localparam int HashW    = 32;
  localparam int DivSteps = HashW;
  localparam int DivCntW  = $clog2(DivSteps);

  // Queue between front and back
  localparam int QDepth  = 2;
  localparam int QPtrW   = 1;
  localparam int QCountW = 2;

  // One finished key handed from the front to the back
  typedef struct packed {
    logic             empty_key;  // zero-length key: answer 0/0
    logic [HashW-1:0] hash;       // accumulator after the last full group
    logic [23:0]      pend;       // unfinished group bytes, first byte low
    logic [1:0]       tail;       // byte count modulo 4
  } kh_entry_t;

  // Queue status toward its neighbors
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [QCountW-1:0] count;
  } kh_qstat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TAIL,
    BK_AVA1,
    BK_AVA2,
    BK_DIV,
    BK_LOAD
  } kh_bstate_t;

endpackage

>>> rtl/core/kh_front.sv
// Front end: takes one key byte per transaction and runs the group mix.
// Depends on kh_pkg; pushes finished keys into kh_queue.
module kh_front
  import kh_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic [7:0] key_length,
  input  logic [7:0] key_byte,
  input  logic      last_byte,
  output logic      push,
  output kh_entry_t push_entry
);

  logic [HashW-1:0] acc_r, acc_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [23:0]      pend_r, pend_nxt;

  logic             start;
  logic [HashW-1:0] h0, h1, hm, tm;
  logic [23:0]      pend0, pend1;
  logic [15:0]      lo, hi;
  logic [8:0]       count;
  logic             last_eff;
  logic             empty_key;

  // Seed, group mix and key closing
  always_comb begin
    start     = (pos_r == 8'd0);
    empty_key = start && (key_length == 8'd0);
    h0        = start ? {24'd0, key_length} : acc_r;
    pend0     = start ? 24'd0 : pend_r;
    lo        = pend0[15:0];
    hi        = {key_byte, pend0[23:16]};
    hm        = h0 + {16'd0, lo};
    tm        = ({16'd0, hi} << 11) ^ hm;
    hm        = (hm << 16) ^ tm;
    hm        = hm + (hm >> 11);
    pend1     = pend0;
    h1        = h0;
    case (pos_r[1:0])
      2'd0: pend1[7:0]   = key_byte;
      2'd1: pend1[15:8]  = key_byte;
      2'd2: pend1[23:16] = key_byte;
      default: begin
        h1    = hm;
        pend1 = 24'd0;
      end
    endcase
    count    = {1'b0, pos_r} + 9'd1;
    last_eff = last_byte || (count >= 9'(MAX_KEY_BYTES));

    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    push     = 1'b0;
    push_entry.empty_key = empty_key;
    push_entry.hash      = h1;
    push_entry.pend      = pend1;
    push_entry.tail      = count[1:0];
    if (fire) begin
      if (empty_key || last_eff) begin
        push     = 1'b1;
        acc_nxt  = '0;
        pos_nxt  = '0;
        pend_nxt = '0;
      end else begin
        acc_nxt  = h1;
        pos_nxt  = count[7:0];
        pend_nxt = pend1;
      end
    end
  end

  // Hold the running key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pos_r  <= '0;
      pend_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

>>> rtl/core/kh_queue.sv
// Two-entry queue of finished keys between front and back.
// Depends on kh_pkg for the entry and status types.
module kh_queue
  import kh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  kh_entry_t push_entry,
  input  logic      pop,
  output kh_entry_t head,
  output kh_qstat_t stat
);

  kh_entry_t          mem_r [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCountW-1:0] count_r, count_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCountW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCountW'(QDepth));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

>>> rtl/core/kh_back.sv
// Back end: tail mix, avalanche, bit-serial modulo and the output register.
// Depends on kh_pkg; pops finished keys from kh_queue.
module kh_back
  import kh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  kh_qstat_t        qstat,
  input  kh_entry_t        head,
  input  logic [8:0]       eff_slices,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [HashW-1:0] out_hash_value,
  output logic [7:0]       out_slice_index
);

  kh_bstate_t         state_r, state_nxt;
  logic [HashW-1:0]   hash_r, hash_nxt;
  logic [HashW-1:0]   shift_r, shift_nxt;
  logic [8:0]         rem_r, rem_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [23:0]        pend_r, pend_nxt;
  logic [1:0]         tail_r, tail_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [HashW-1:0]   out_hash_r, out_hash_nxt;
  logic [7:0]         out_idx_r, out_idx_nxt;

  logic [HashW-1:0]   t, a;
  logic [7:0]         b0, b1, b2;
  logic [8:0]         r;
  logic               out_free;

  // Sequence one key at a time
  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    shift_nxt     = shift_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    tail_nxt      = tail_r;
    out_hash_nxt  = out_hash_r;
    out_idx_nxt   = out_idx_r;
    pop           = 1'b0;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    b0            = pend_r[7:0];
    b1            = pend_r[15:8];
    b2            = pend_r[23:16];
    t             = hash_r;
    a             = hash_r;
    r             = {rem_r[7:0], shift_r[HashW-1]};

    case (state_r)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop      = 1'b1;
          hash_nxt = head.hash;
          pend_nxt = head.pend;
          tail_nxt = head.tail;
          if (head.empty_key) begin
            hash_nxt  = '0;
            rem_nxt   = '0;
            state_nxt = BK_LOAD;
          end else begin
            state_nxt = BK_TAIL;
          end
        end
      end
      BK_TAIL: begin
        // Mix the one- to three-byte tail
        case (tail_r)
          2'd3: begin
            t = hash_r + {16'd0, b1, b0};
            t = t ^ (t << 16);
            t = t ^ ({{24{b2[7]}}, b2} << 18);
            t = t + (t >> 11);
          end
          2'd2: begin
            t = hash_r + {16'd0, b1, b0};
            t = t ^ (t << 11);
            t = t + (t >> 17);
          end
          2'd1: begin
            t = hash_r + {{24{b0[7]}}, b0};
            t = t ^ (t << 10);
            t = t + (t >> 1);
          end
          default: t = hash_r;
        endcase
        hash_nxt  = t;
        state_nxt = BK_AVA1;
      end
      BK_AVA1: begin
        a         = hash_r ^ (hash_r << 3);
        a         = a + (a >> 5);
        a         = a ^ (a << 4);
        hash_nxt  = a;
        state_nxt = BK_AVA2;
      end
      BK_AVA2: begin
        a         = hash_r + (hash_r >> 17);
        a         = a ^ (a << 25);
        a         = a + (a >> 6);
        hash_nxt  = a;
        shift_nxt = a;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        // One restoring step per cycle, MSB first
        if (r >= eff_slices) begin
          r = r - eff_slices;
        end
        rem_nxt   = r;
        shift_nxt = shift_r << 1;
        cnt_nxt   = cnt_r + DivCntW'(1);
        if (cnt_r == DivCntW'(DivSteps - 1)) begin
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = hash_r;
          out_idx_nxt   = rem_r[7:0];
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    hash_r     <= hash_nxt;
    shift_r    <= shift_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    tail_r     <= tail_nxt;
    out_hash_r <= out_hash_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hash_value  = out_hash_r;
  assign out_slice_index = out_idx_r;

endmodule

>>> rtl/core/key_hash_slice_select_core.sv
// Key hash slice selector: streaming 32-bit key hash and slice reduction.
// Depends on kh_pkg, kh_front, kh_queue and kh_back.
//
// Keys arrive one byte per transaction. The front end takes a byte every cycle
// unless the queue is full, and it mixes each full 4-byte group as it completes.
// A finished key moves through a two-entry queue to the back end, which pops it,
// runs the tail mix, the avalanche (BK_AVA1, BK_AVA2) and a bit-serial modulo by
// the slice count, one restoring step per hash bit, and then loads the output
// register; while out_stall holds a waiting result, it waits to load. The back
// end takes no new key until the last one is loaded, so its modulo loop bounds
// the key rate for short keys. An empty key (length 0 on its first byte) is one
// transaction, goes from the pop straight to the output load and returns hash 0,
// slice 0. The slice count register reads 0 as 1 and saturates at the smaller of
// 256 and MAX_SLICES; write it only while the block is idle.
module key_hash_slice_select_core
  import kh_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 255,
  parameter int MAX_SLICES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_length,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  output logic [7:0]  out_slice_index
);

  localparam int SliceCap = (MAX_SLICES < 256) ? MAX_SLICES : 256;

  logic [8:0] slice_count_r;
  logic [8:0] eff_slices;
  logic       in_fire;
  logic       push;
  logic       pop;
  kh_entry_t  push_entry;
  kh_entry_t  head;
  kh_qstat_t  qstat;

  // Slice count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_count_r <= 9'd1;
    end else if (cfg_wr_en) begin
      slice_count_r <= cfg_wr_data;
    end
  end

  // Clamp the slice count to its usable range
  always_comb begin
    eff_slices = slice_count_r;
    if (slice_count_r == 9'd0) begin
      eff_slices = 9'd1;
    end else if (slice_count_r > 9'(SliceCap)) begin
      eff_slices = 9'(SliceCap);
    end
  end

  assign in_stall = qstat.full;
  assign in_fire  = in_valid && !in_stall;

  kh_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .key_length(in_key_length),
    .key_byte  (in_key_byte),
    .last_byte (in_last_byte),
    .push      (push),
    .push_entry(push_entry)
  );

  kh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  kh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qstat          (qstat),
    .head           (head),
    .eff_slices     (eff_slices),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .out_slice_index(out_slice_index)
  );

  // Slice index stays below the effective slice count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_slice_index} < eff_slices))
    else $error("slice index out of range");

  // Queue never overfills and never pops when empty
  a_q_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.count <= QCountW'(QDepth)) && !(pop && qstat.empty))
    else $error("queue bounds violated");

  // A push into a full queue cannot happen
  a_q_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into full queue");

endmodule

>>> verif/key_hash_slice_select_core_tb.sv
// Testbench for key_hash_slice_select_core: streams keys byte by byte, predicts each
// hash and slice index, and checks every result transaction in order.
// Depends only on the key_hash_slice_select_core RTL.
`timescale 1ns / 1ps

module key_hash_slice_select_core_tb;

  localparam int MAX_KEY_BYTES  = 255;
  localparam int MAX_SLICES     = 256;
  localparam int SLICE_CAP      = (MAX_SLICES < 256) ? MAX_SLICES : 256;
  localparam int PHASE_ITEMS    = 215;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [7:0] klen;
    logic [7:0] kbyte;
    logic       is_last;
  } key_item_t;

  typedef struct {
    logic [31:0] hash_value;
    logic [7:0]  slice_index;
  } hash_result_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_BLOCKS
  } rx_mode_t;

  typedef enum int {
    BYTES_RANDOM,
    BYTES_ONES,
    BYTES_ZEROS,
    BYTES_HIGH
  } byte_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_key_length = '0;
  logic [7:0]  in_key_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;
  logic [7:0]  out_slice_index;

  key_hash_slice_select_core #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .MAX_SLICES   (MAX_SLICES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_length  (in_key_length),
    .in_key_byte    (in_key_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .out_slice_index(out_slice_index)
  );

  // Stimulus, expectations and bookkeeping
  key_item_t    key_bytes_q[$];
  hash_result_t pending_hashes[$];
  int           items_queued = 0;
  int           items_accepted = 0;
  int           err_count = 0;
  int           idle_cycles = 0;
  bit           in_fire;
  bit           out_fire;

  // Predictor state
  logic [31:0] hs_acc = '0;
  logic [7:0]  hs_pos = '0;
  logic [23:0] hs_pend = '0;
  logic [8:0]  hs_slices = 9'd1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sign_byte(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] final_mix(input logic [31:0] v);
    logic [31:0] h;
    h = v;
    h ^= h << 3;
    h += h >> 5;
    h ^= h << 4;
    h += h >> 17;
    h ^= h << 25;
    h += h >> 6;
    return h;
  endfunction

  // Absorb one key byte; on a key close, produce the hash and slice index
  function automatic void hash_absorb_byte(input logic [7:0] klen, input logic [7:0] kb,
                                           input logic last_in, output bit produced,
                                           output hash_result_t res);
    logic [31:0] h, t, lo, hi, nslices;
    logic [8:0]  count;
    logic [7:0]  b0, b1, b2;
    logic        closes;
    int          slot;
    produced = 1'b0;
    res = '{hash_value: '0, slice_index: '0};
    closes = last_in;
    if (hs_pos == 8'd0) begin
      if (klen == 8'd0) begin
        // empty key: answer zero regardless of the last flag
        hs_acc = '0;
        hs_pend = '0;
        produced = 1'b1;
        return;
      end
      hs_acc = {24'b0, klen};
      hs_pend = '0;
    end
    h = hs_acc;
    slot = int'(hs_pos[1:0]);
    if (slot < 3) begin
      hs_pend[8*slot +: 8] = kb;
    end else begin
      // mix a full group as two little-endian halves
      lo = {16'b0, hs_pend[15:0]};
      hi = {16'b0, kb, hs_pend[23:16]};
      h += lo;
      t = (hi << 11) ^ h;
      h = (h << 16) ^ t;
      h += h >> 11;
      hs_pend = '0;
    end
    count = {1'b0, hs_pos} + 9'd1;
    if (count >= MAX_KEY_BYTES) closes = 1'b1;
    if (!closes) begin
      hs_acc = h;
      hs_pos = count[7:0];
      return;
    end
    b0 = hs_pend[7:0];
    b1 = hs_pend[15:8];
    b2 = hs_pend[23:16];
    case (count[1:0])
      2'd3: begin
        h += {16'b0, b1, b0};
        h ^= h << 16;
        h ^= sign_byte(b2) << 18;
        h += h >> 11;
      end
      2'd2: begin
        h += {16'b0, b1, b0};
        h ^= h << 11;
        h += h >> 17;
      end
      2'd1: begin
        h += sign_byte(b0);
        h ^= h << 10;
        h += h >> 1;
      end
      default: begin
      end
    endcase
    h = final_mix(h);
    if (hs_slices == 9'd0) nslices = 32'd1;
    else if (hs_slices > SLICE_CAP) nslices = SLICE_CAP;
    else nslices = {23'b0, hs_slices};
    res.hash_value = h;
    res.slice_index = 8'(h % nslices);
    produced = 1'b1;
    hs_acc = '0;
    hs_pos = '0;
    hs_pend = '0;
  endfunction

  // Sample both channels, predict accepted bytes, check results, run the watchdog
  always @(posedge clk) begin
    hash_result_t want, pred;
    bit           produced;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (out_fire) begin
      if (pending_hashes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result hash_value %h slice_index %h", $time,
                 out_hash_value, out_slice_index);
      end else begin
        want = pending_hashes.pop_front();
        if (out_hash_value !== want.hash_value) begin
          err_count++;
          $display("%0t: hash_value expected %h actual %h", $time, want.hash_value,
                   out_hash_value);
        end
        if (out_slice_index !== want.slice_index) begin
          err_count++;
          $display("%0t: slice_index expected %h actual %h", $time, want.slice_index,
                   out_slice_index);
        end
      end
    end
    if (in_fire) begin
      hash_absorb_byte(in_key_length, in_key_byte, in_last_byte, produced, pred);
      if (produced) pending_hashes.push_back(pred);
      items_accepted++;
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_hashes.size());
      $display("key_hash_slice_select_core verification failed");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps
  int send_gap = 0;
  int burst_left = 1;

  always @(negedge clk) begin
    key_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (key_bytes_q.size() > 0) begin
        nxt = key_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_key_length <= nxt.klen;
        in_key_byte <= nxt.kbyte;
        in_last_byte <= nxt.is_last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that switches mode at random intervals
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_span = 0;
  int       rx_run = 0;
  bit       rx_hold = 1'b0;

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          rx_hold = !rx_hold;
          rx_run = rx_hold ? $urandom_range(5, 20) : $urandom_range(1, 10);
        end else begin
          rx_run--;
        end
        out_stall <= rx_hold;
      end
    endcase
  end

  task automatic queue_item(input logic [7:0] klen, input logic [7:0] kb, input logic last_in);
    key_bytes_q.push_back('{klen: klen, kbyte: kb, is_last: last_in});
    items_queued++;
  endtask

  function automatic logic [7:0] pick_byte(input byte_style_t style);
    case (style)
      BYTES_ONES:  return 8'hFF;
      BYTES_ZEROS: return 8'h00;
      BYTES_HIGH:  return 8'h80 | 8'($urandom_range(0, 127));
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue n bytes of one key; scramble varies the length field after the first byte
  task automatic queue_key(input int n, input logic [7:0] klen, input bit closes,
                           input byte_style_t style, input bit scramble);
    logic [7:0] lf;
    for (int k = 0; k < n; k++) begin
      lf = (k == 0 || !scramble) ? klen : 8'($urandom_range(0, 255));
      queue_item(lf, pick_byte(style), closes && (k == n - 1));
    end
  endtask

  task automatic queue_random_key();
    int          r, n;
    byte_style_t style;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       style = BYTES_ONES;
      1:       style = BYTES_ZEROS;
      2:       style = BYTES_HIGH;
      default: style = BYTES_RANDOM;
    endcase
    if (r < 8) begin
      // empty key, last flag either way
      queue_item(8'd0, pick_byte(style), 1'($urandom_range(0, 1)));
    end else if (r < 60) begin
      n = $urandom_range(1, 12);
      queue_key(n, 8'(n), 1'b1, style, 1'b0);
    end else if (r < 75) begin
      n = $urandom_range(13, 64);
      queue_key(n, 8'(n), 1'b1, style, 1'b0);
    end else if (r < 77) begin
      // long key, sometimes running past the byte limit without a last flag
      n = $urandom_range(200, 270);
      queue_key(n, 8'($urandom_range(1, 255)), n < MAX_KEY_BYTES, style, 1'b0);
    end else if (r < 88) begin
      // length field disagrees with the bytes sent
      n = $urandom_range(1, 16);
      queue_key(n, 8'($urandom_range(1, 255)), 1'b1, style, 1'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) begin
        queue_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 2) == 0));
      end
    end
  endtask

  // Wait until every queued byte is taken and every result has come, then settle
  task automatic drain_and_settle();
    while (!(items_accepted == items_queued && pending_hashes.size() == 0)) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_slice_count(input logic [8:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    hs_slices = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [8:0] slice_plan[7];
    int         start;
    slice_plan = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd257, 9'($urandom_range(2, 255)), 9'd3};

    // Hold reset, then release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty keys, every tail size, sign extension, length mismatch
    write_slice_count(9'd7);
    queue_item(8'd0, 8'hFF, 1'b1);
    queue_item(8'd0, 8'h00, 1'b0);
    queue_item(8'd1, 8'h80, 1'b1);
    queue_item(8'd1, 8'h7F, 1'b1);
    queue_key(2, 8'd2, 1'b1, BYTES_ONES, 1'b0);
    queue_item(8'd3, 8'h00, 1'b0);
    queue_item(8'd3, 8'h00, 1'b0);
    queue_item(8'd3, 8'h80, 1'b1);
    queue_item(8'd3, 8'hFF, 1'b0);
    queue_item(8'd3, 8'hFF, 1'b0);
    queue_item(8'd3, 8'h7F, 1'b1);
    queue_key(4, 8'd4, 1'b1, BYTES_ONES, 1'b0);
    queue_key(5, 8'd5, 1'b1, BYTES_ZEROS, 1'b0);
    queue_key(2, 8'd255, 1'b1, BYTES_RANDOM, 1'b0);
    queue_item(8'd1, 8'h12, 1'b0);
    queue_item(8'd0, 8'h34, 1'b0);
    queue_item(8'd255, 8'h56, 1'b1);
    drain_and_settle();

    // Random phases, one slice count each
    foreach (slice_plan[p]) begin
      write_slice_count(slice_plan[p]);
      start = items_queued;
      if (p == 0) queue_key(262, 8'd255, 1'b0, BYTES_RANDOM, 1'b0);
      while (items_queued - start < PHASE_ITEMS) queue_random_key();
      // close whatever key is open so the block ends the phase idle
      queue_item(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 1'b1);
      drain_and_settle();
    end

    if (err_count == 0) begin
      $display("key_hash_slice_select_core verification clean");
    end else begin
      $display("key_hash_slice_select_core verification failed");
    end
    $finish;
  end

endmodule
